/* rtl/swmmm_pkg.sv */
// Shared types and constants for the sliding window max/min/mean block.
// No dependencies; imported by the divider, the top level and the testbench.
`timescale 1ns / 1ps

package swmmm_pkg;

   // width of the window length register
   localparam int LEN_REG_WIDTH = 9;

   // result kind codes
   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_SERIES = 1'b1;

   // divider status as seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/swmmm_store.sv */
// Ring store of recent samples: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module swmmm_store #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 32,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/swmmm_div.sv */
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on swmmm_pkg for the status struct.
`timescale 1ns / 1ps

module swmmm_div
   import swmmm_pkg::*;
#(
   parameter int DVD_W = 52,
   parameter int DVS_W = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic        [DVS_W-1:0] divisor,
   output logic signed [DVD_W-1:0] quotient,
   output div_status_type          status
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic              busy_ff;
   logic              fix_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DVS_W:0]    rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic signed [DVD_W-1:0] q_ff;

   logic [DVS_W:0]    rem_sh;
   logic [DVS_W+1:0]  diff;
   logic              q_bit;
   logic [DVS_W:0]    rem_in;
   logic [DVD_W-1:0]  mag_in;

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff[DVS_W-1:0], dvd_ff[DVD_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
      q_bit  = ~diff[DVS_W+1];
      rem_in = q_bit ? diff[DVS_W:0] : rem_sh;
      mag_in = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            fix_ff  <= 1'b0;
            cnt_ff  <= '0;
            neg_ff  <= dividend[DVD_W-1];
            dvd_ff  <= mag_in;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff && !fix_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[DVD_W-2:0], q_bit};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               fix_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            // apply the sign
            q_ff    <= neg_ff ? (~dvd_ff + 1'b1) : dvd_ff;
            busy_ff <= 1'b0;
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quotient    = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* rtl/sliding_window_max_min_mean.sv */
// Sliding window max/min/mean over a signed fixed-point series.
// Depends on swmmm_pkg, swmmm_store and swmmm_div.
//
//   channel   direction  handshake              words
//   req_      in         req_valid / req_stall  sample, is_last
//   rsp_      out        rsp_valid / rsp_stall  kind, window_start, max, min, mean, final
//   csr_      in         csr_write_enable       window_length (9 bits)
//
// Steps: a window result rescans the ring store (one read a cycle, read data registered),
// starts the divider, waits for its done and then hands off the word; a final sample
// then runs the divider again for the series mean.
// Reset is synchronous and active high; window length resets to 1, the store is not cleared.
// req_stall rises once a sample that yields a result is accepted and stays high until
// its last result is taken; rsp_stall holds the result register and the sequencer.
`timescale 1ns / 1ps

module sliding_window_max_min_mean
   import swmmm_pkg::*;
#(
   parameter int WINDOW_MAX   = 256,
   parameter int COUNT_WIDTH  = 20,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [LEN_REG_WIDTH-1:0]       csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_is_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [COUNT_WIDTH-1:0]         rsp_window_start,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_max_value,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_min_value,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_mean_value,
   output logic                           rsp_final_of_run
);

   localparam int SUM_BITS = (SAMPLE_WIDTH + COUNT_WIDTH > 63) ? 63
                                                               : SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int PTR_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_W    = $clog2(WINDOW_MAX + 1);
   localparam int DVS_W    = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
   localparam int EXT_W    = SUM_BITS - SAMPLE_WIDTH;

   localparam logic signed [SUM_BITS-1:0] S_HI =
      {{(EXT_W + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] S_LO = ~S_HI;
   localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS - 1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_LO = ~SUM_HI;
   localparam logic signed [SAMPLE_WIDTH-1:0] SMP_HI = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SMP_LO = ~SMP_HI;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WSTART,
      ST_WDIV,
      ST_WOUT,
      ST_SSTART,
      ST_SDIV,
      ST_SOUT
   } state_type;

   state_type state_ff;

   logic [LEN_REG_WIDTH-1:0]       window_length_ff;
   logic [PTR_W-1:0]               wp_ff;
   logic [COUNT_WIDTH-1:0]         count_ff;
   logic signed [SAMPLE_WIDTH-1:0] series_max_ff;
   logic signed [SAMPLE_WIDTH-1:0] series_min_ff;
   logic signed [SUM_BITS-1:0]     series_sum_ff;
   logic                           last_ff;
   logic [LEN_W-1:0]               len_ff;
   logic [COUNT_WIDTH-1:0]         wstart_ff;
   logic [PTR_W-1:0]               scan_ptr_ff;
   logic [LEN_W-1:0]               issue_cnt_ff;
   logic [LEN_W-1:0]               got_cnt_ff;
   logic                           pend_ff;
   logic signed [SAMPLE_WIDTH-1:0] wmax_ff;
   logic signed [SAMPLE_WIDTH-1:0] wmin_ff;
   logic signed [SUM_BITS-1:0]     wsum_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_kind_ff;
   logic [COUNT_WIDTH-1:0]         rsp_window_start_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_max_value_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_min_value_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_mean_value_ff;
   logic                           rsp_final_of_run_ff;

   logic                           accept;
   logic [31:0]                    len32;
   logic [LEN_W-1:0]               len_in;
   logic [31:0]                    wp_nxt32;
   logic [31:0]                    base32;
   logic [PTR_W-1:0]               wp_in;
   logic [COUNT_WIDTH-1:0]         count_in;
   logic [DVS_W-1:0]               count_x;
   logic [DVS_W-1:0]               len_x;
   logic                           window_due;
   logic signed [SUM_BITS-1:0]     sample_x;
   logic signed [SUM_BITS:0]       sum_wide;
   logic signed [SUM_BITS-1:0]     series_sum_in;
   logic [PTR_W-1:0]               scan_ptr_in;

   logic                           rd_en;
   logic signed [SAMPLE_WIDTH-1:0] rd_data;
   logic signed [SUM_BITS-1:0]     rd_x;

   logic                           div_start;
   logic signed [SUM_BITS-1:0]     div_dividend;
   logic [DVS_W-1:0]               div_divisor;
   logic signed [SUM_BITS-1:0]     div_q;
   div_status_type                 div_stat;
   logic signed [SAMPLE_WIDTH-1:0] series_mean;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // effective window length, clamped to 1..WINDOW_MAX
   always_comb begin
      if (window_length_ff == '0) begin
         len32 = 32'd1;
      end else if (32'(window_length_ff) > 32'(WINDOW_MAX)) begin
         len32 = 32'(WINDOW_MAX);
      end else begin
         len32 = 32'(window_length_ff);
      end
      len_in = LEN_W'(len32);
   end

   // ring pointer, count and first read address for the new word
   always_comb begin
      wp_nxt32 = 32'(wp_ff) + 32'd1;
      if (wp_nxt32 == 32'(WINDOW_MAX)) begin
         wp_nxt32 = 32'd0;
      end
      wp_in = PTR_W'(wp_nxt32);
      if (wp_nxt32 >= len32) begin
         base32 = wp_nxt32 - len32;
      end else begin
         base32 = wp_nxt32 + 32'(WINDOW_MAX) - len32;
      end
      count_in   = (count_ff == {COUNT_WIDTH{1'b1}}) ? count_ff : count_ff + 1'b1;
      count_x    = DVS_W'(count_in);
      len_x      = DVS_W'(len_in);
      window_due = (count_x >= len_x);
   end

   // saturating series sum
   always_comb begin
      sample_x = {{EXT_W{req_sample[SAMPLE_WIDTH-1]}}, req_sample};
      sum_wide = {series_sum_ff[SUM_BITS-1], series_sum_ff}
               + {sample_x[SUM_BITS-1], sample_x};
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         series_sum_in = sum_wide[SUM_BITS] ? SUM_LO : SUM_HI;
      end else begin
         series_sum_in = sum_wide[SUM_BITS-1:0];
      end
   end

   // scan address step
   always_comb begin
      if (32'(scan_ptr_ff) == 32'(WINDOW_MAX - 1)) begin
         scan_ptr_in = '0;
      end else begin
         scan_ptr_in = scan_ptr_ff + 1'b1;
      end
   end

   assign rd_en = (state_ff == ST_SCAN) && (issue_cnt_ff != len_ff);
   assign rd_x  = {{EXT_W{rd_data[SAMPLE_WIDTH-1]}}, rd_data};

   // series mean, clamped to the sample range
   always_comb begin
      if (div_q > S_HI) begin
         series_mean = SMP_HI;
      end else if (div_q < S_LO) begin
         series_mean = SMP_LO;
      end else begin
         series_mean = div_q[SAMPLE_WIDTH-1:0];
      end
   end

   // divider operands
   always_comb begin
      div_start    = (state_ff == ST_WSTART) || (state_ff == ST_SSTART);
      div_dividend = (state_ff == ST_WSTART) ? wsum_ff : series_sum_ff;
      div_divisor  = (state_ff == ST_WSTART) ? DVS_W'(len_ff) : DVS_W'(count_ff);
   end

   swmmm_store #(
      .DEPTH  (WINDOW_MAX),
      .DATA_W (SAMPLE_WIDTH),
      .ADDR_W (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (scan_ptr_ff),
      .rd_data (rd_data)
   );

   swmmm_div #(
      .DVD_W (SUM_BITS),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .status   (div_stat)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= LEN_REG_WIDTH'(1);
      end else if (csr_write_enable) begin
         window_length_ff <= csr_write_data;
      end
   end

   // sequencer, series state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         count_ff      <= '0;
         series_max_ff <= SMP_LO;
         series_min_ff <= SMP_HI;
         series_sum_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_ff <= rd_en;
         if (rd_en) begin
            scan_ptr_ff  <= scan_ptr_in;
            issue_cnt_ff <= issue_cnt_ff + 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  wp_ff         <= wp_in;
                  count_ff      <= count_in;
                  series_sum_ff <= series_sum_in;
                  if (req_sample > series_max_ff) begin
                     series_max_ff <= req_sample;
                  end
                  if (req_sample < series_min_ff) begin
                     series_min_ff <= req_sample;
                  end
                  last_ff      <= req_is_last;
                  len_ff       <= len_in;
                  wstart_ff    <= COUNT_WIDTH'(count_x - len_x);
                  scan_ptr_ff  <= PTR_W'(base32);
                  issue_cnt_ff <= '0;
                  got_cnt_ff   <= '0;
                  if (window_due) begin
                     state_ff <= ST_SCAN;
                  end else if (req_is_last) begin
                     state_ff <= ST_SSTART;
                  end
               end
            end
            ST_SCAN: begin
               // fold in one stored word per cycle
               if (pend_ff) begin
                  if (got_cnt_ff == '0) begin
                     wmax_ff <= rd_data;
                     wmin_ff <= rd_data;
                     wsum_ff <= rd_x;
                  end else begin
                     if (rd_data > wmax_ff) begin
                        wmax_ff <= rd_data;
                     end
                     if (rd_data < wmin_ff) begin
                        wmin_ff <= rd_data;
                     end
                     wsum_ff <= wsum_ff + rd_x;
                  end
                  got_cnt_ff <= got_cnt_ff + 1'b1;
                  if (got_cnt_ff == len_ff - 1'b1) begin
                     state_ff <= ST_WSTART;
                  end
               end
            end
            ST_WSTART: begin
               state_ff <= ST_WDIV;
            end
            ST_WDIV: begin
               if (div_stat.done) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_kind_ff         <= KIND_WINDOW;
                  rsp_window_start_ff <= wstart_ff;
                  rsp_max_value_ff    <= wmax_ff;
                  rsp_min_value_ff    <= wmin_ff;
                  rsp_mean_value_ff   <= div_q[SAMPLE_WIDTH-1:0];
                  rsp_final_of_run_ff <= !last_ff;
                  state_ff            <= ST_WOUT;
               end
            end
            ST_WOUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= last_ff ? ST_SSTART : ST_IDLE;
               end
            end
            ST_SSTART: begin
               state_ff <= ST_SDIV;
            end
            ST_SDIV: begin
               if (div_stat.done) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_kind_ff         <= KIND_SERIES;
                  rsp_window_start_ff <= '0;
                  rsp_max_value_ff    <= series_max_ff;
                  rsp_min_value_ff    <= series_min_ff;
                  rsp_mean_value_ff   <= series_mean;
                  rsp_final_of_run_ff <= 1'b1;
                  state_ff            <= ST_SOUT;
               end
            end
            ST_SOUT: begin
               // series done: clear and wait for the next one
               if (!rsp_stall) begin
                  rsp_valid_ff  <= 1'b0;
                  wp_ff         <= '0;
                  count_ff      <= '0;
                  series_max_ff <= SMP_LO;
                  series_min_ff <= SMP_HI;
                  series_sum_ff <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_window_start = rsp_window_start_ff;
   assign rsp_max_value    = rsp_max_value_ff;
   assign rsp_min_value    = rsp_min_value_ff;
   assign rsp_mean_value   = rsp_mean_value_ff;
   assign rsp_final_of_run = rsp_final_of_run_ff;

   // a result is only shown while the sequencer waits on it
   a_rsp_in_out_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_WOUT || state_ff == ST_SOUT))
      else $error("result valid outside an output state");

   // divider finishes only while it is awaited
   a_div_done_awaited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_WDIV || state_ff == ST_SDIV))
      else $error("divider done while not awaited");

   // divider never restarted mid-run
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // window start plus length equals the sample count
   a_window_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_WINDOW)
         |-> (DVS_W'(rsp_window_start_ff) + DVS_W'(len_ff) == DVS_W'(count_ff)))
      else $error("window start does not match count and length");

   // series state is cleared once the series word is taken
   a_series_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SOUT && !rsp_stall) |=> (count_ff == '0 && wp_ff == '0))
      else $error("series state not cleared");

   // max never below min
   a_max_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_max_value_ff >= rsp_min_value_ff))
      else $error("max below min");

endmodule

/* dv/tb.sv */
// Self-checking testbench for sliding_window_max_min_mean.
// Depends on swmmm_pkg and the RTL top level; an in-bench predictor tracks the window
// and series statistics and every result word is checked in order.
`timescale 1ns / 1ps

module tb;
   import swmmm_pkg::*;

   localparam int SAMPLE_W      = 32;
   localparam int COUNT_W       = 20;
   localparam int WINDOW_DEPTH  = 256;
   localparam int SETTLE_CYCLES = 500;
   localparam int HOLD_CYCLES   = 600;
   localparam int HOLD_SPACING  = 700;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = 32'sh7fffffff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 32'sh80000000;
   localparam logic [COUNT_W-1:0]         COUNT_TOP     = '1;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic                       last;
   } sample_word_type;

   typedef struct {
      logic                       kind;
      logic [COUNT_W-1:0]         start;
      logic signed [SAMPLE_W-1:0] max_v;
      logic signed [SAMPLE_W-1:0] min_v;
      logic signed [SAMPLE_W-1:0] mean_v;
      logic                       fin;
   } stats_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [LEN_REG_WIDTH-1:0]   csr_write_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_is_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_kind;
   logic [COUNT_W-1:0]         rsp_window_start;
   logic signed [SAMPLE_W-1:0] rsp_max_value;
   logic signed [SAMPLE_W-1:0] rsp_min_value;
   logic signed [SAMPLE_W-1:0] rsp_mean_value;
   logic                       rsp_final_of_run;

   // words waiting to be sent, statistics waiting to come back
   sample_word_type samples_pending[$];
   stats_word_type  stats_due[$];
   sample_word_type next_word;

   // predictor state
   logic signed [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
   logic [7:0]                 wr_ptr;
   logic [COUNT_W-1:0]         seen_count;
   logic signed [SAMPLE_W-1:0] run_max;
   logic signed [SAMPLE_W-1:0] run_min;
   logic signed [51:0]         run_sum;
   logic [LEN_REG_WIDTH-1:0]   len_reg;

   bit no_gaps        = 1'b0;
   int mismatch_count = 0;
   int taken_count    = 0;
   int hold_left      = 0;
   int next_hold_at   = 60;

   sliding_window_max_min_mean i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_window_start (rsp_window_start),
      .rsp_max_value    (rsp_max_value),
      .rsp_min_value    (rsp_min_value),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_final_of_run (rsp_final_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // series state back to empty; the window length is kept
   task automatic clear_series();
      wr_ptr     = '0;
      seen_count = '0;
      run_max    = SAMPLE_BOTTOM;
      run_min    = SAMPLE_TOP;
      run_sum    = '0;
   endtask

   // fold one accepted sample in and queue the statistics it yields
   task automatic fold_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
      int                         len;
      longint                     v64;
      longint                     acc;
      longint                     hi;
      longint                     lo;
      longint                     mean;
      longint                     cnt64;
      logic [7:0]                 idx;
      logic signed [SAMPLE_W-1:0] mx;
      logic signed [SAMPLE_W-1:0] mn;
      logic signed [SAMPLE_W-1:0] entry;
      stats_word_type             w;
      len = int'(len_reg);
      if (len == 0) len = 1;
      if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;

      ring[wr_ptr] = value;
      wr_ptr = wr_ptr + 8'd1;
      if (seen_count != COUNT_TOP) seen_count = seen_count + 1'b1;
      if (value > run_max) run_max = value;
      if (value < run_min) run_min = value;

      // saturating series sum at 52 bits
      v64 = value;
      acc = run_sum;
      hi  = (longint'(1) << 51) - 1;
      lo  = -hi - 1;
      if (v64 > 0 && acc > hi - v64) acc = hi;
      else if (v64 < 0 && acc < lo - v64) acc = lo;
      else acc = acc + v64;
      run_sum = acc[51:0];

      // window over the last len samples
      if (seen_count >= len) begin
         idx = wr_ptr - len[7:0];
         mx  = ring[idx];
         mn  = mx;
         acc = 0;
         for (int k = 0; k < len; k++) begin
            entry = ring[idx];
            acc   = acc + longint'(entry);
            if (entry > mx) mx = entry;
            if (entry < mn) mn = entry;
            idx = idx + 8'd1;
         end
         mean     = acc / longint'(len);
         w.kind   = KIND_WINDOW;
         w.start  = seen_count - COUNT_W'(len);
         w.max_v  = mx;
         w.min_v  = mn;
         w.mean_v = mean[SAMPLE_W-1:0];
         w.fin    = !last;
         stats_due.push_back(w);
      end

      // whole-series result on the closing sample
      if (last) begin
         acc   = run_sum;
         cnt64 = seen_count;
         mean  = acc / cnt64;
         if (mean > longint'(SAMPLE_TOP)) mean = SAMPLE_TOP;
         if (mean < longint'(SAMPLE_BOTTOM)) mean = SAMPLE_BOTTOM;
         w.kind   = KIND_SERIES;
         w.start  = '0;
         w.max_v  = run_max;
         w.min_v  = run_min;
         w.mean_v = mean[SAMPLE_W-1:0];
         w.fin    = 1'b1;
         stats_due.push_back(w);
         clear_series();
      end
   endtask

   // driver: config tracking, prediction on accept, next word from the queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         len_reg = 9'd1;
         clear_series();
      end else begin
         if (csr_write_enable) len_reg = csr_write_data;
         if (req_valid && !req_stall) fold_sample(req_sample, req_is_last);
         if (!req_valid || !req_stall) begin
            if (samples_pending.size() != 0 && (no_gaps || $urandom_range(99) >= 16)) begin
               next_word = samples_pending.pop_front();
               req_valid   <= 1'b1;
               req_sample  <= next_word.value;
               req_is_last <= next_word.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // compare one taken result word against the oldest expectation
   task automatic check_result();
      stats_word_type got;
      stats_word_type want;
      got.kind   = rsp_kind;
      got.start  = rsp_window_start;
      got.max_v  = rsp_max_value;
      got.min_v  = rsp_min_value;
      got.mean_v = rsp_mean_value;
      got.fin    = rsp_final_of_run;
      taken_count++;
      if (stats_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected word: kind %0d start %0d max %0d min %0d mean %0d fin %0d",
                     got.kind, got.start, got.max_v, got.min_v, got.mean_v, got.fin);
      end else begin
         want = stats_due.pop_front();
         if (got.kind !== want.kind || got.start !== want.start ||
             got.max_v !== want.max_v || got.min_v !== want.min_v ||
             got.mean_v !== want.mean_v || got.fin !== want.fin) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("mismatch at word %0d", taken_count);
               $display("  expected kind %0d start %0d max %0d min %0d mean %0d fin %0d",
                        want.kind, want.start, want.max_v, want.min_v, want.mean_v,
                        want.fin);
               $display("  actual   kind %0d start %0d max %0d min %0d mean %0d fin %0d",
                        got.kind, got.start, got.max_v, got.min_v, got.mean_v, got.fin);
            end
         end
      end
   endtask

   // monitor: take results, random stalls, long hold-offs at set counts of results taken
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         rsp_stall <= (hold_left > 0) || (!no_gaps && $urandom_range(99) < 16);
      end
   end

   // hold-off counter, kept on the falling edge so the monitor sees a settled value
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end else if (!no_gaps && taken_count >= next_hold_at) begin
         hold_left    = HOLD_CYCLES;
         next_hold_at = next_hold_at + HOLD_SPACING;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 3) return SAMPLE_TOP;
      if (r < 6) return SAMPLE_BOTTOM;
      if (r < 8) return '0;
      if (r < 10) return -1;
      if (r < 50) return $urandom;
      return int'($urandom_range(0, 2097152)) - 1048576;
   endfunction

   task automatic add_word(input logic signed [SAMPLE_W-1:0] value, input logic last);
      sample_word_type w;
      w.value = value;
      w.last  = last;
      samples_pending.push_back(w);
   endtask

   task automatic add_series(input int n, input bit closed);
      for (int i = 0; i < n; i++) add_word(pick_sample(), closed && (i == n - 1));
   endtask

   // register write; only called with the block idle
   task automatic set_length(input logic [LEN_REG_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // wait for every word sent and every result back, then let the block settle
   task automatic finish_phase();
      while (samples_pending.size() != 0 || req_valid || stats_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // stimulus
   initial begin
      int len;
      int added;
      int n;
      int r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset length of one: extremes, single-sample series, truncation of series mean
      add_word(SAMPLE_TOP, 1'b0);
      add_word(SAMPLE_BOTTOM, 1'b0);
      add_word(0, 1'b0);
      add_word(-1, 1'b0);
      add_word(1, 1'b1);
      add_word(SAMPLE_BOTTOM, 1'b1);
      add_word(SAMPLE_TOP, 1'b1);
      add_word(SAMPLE_BOTTOM, 1'b0);
      add_word(SAMPLE_BOTTOM, 1'b1);
      add_word(-7, 1'b0);
      add_word(2, 1'b1);
      finish_phase();

      // length two: window means rounding toward zero, full-scale sums
      set_length(9'd2);
      add_word(-3, 1'b0);
      add_word(0, 1'b0);
      add_word(7, 1'b1);
      add_word(5, 1'b0);
      add_word(-8, 1'b1);
      add_word(SAMPLE_TOP, 1'b0);
      add_word(SAMPLE_TOP, 1'b1);
      finish_phase();

      // length zero behaves as one
      set_length(9'd0);
      add_word(5, 1'b0);
      add_word(-5, 1'b1);
      finish_phase();

      // series shorter than the window, then a series left open
      set_length(9'd3);
      add_word(1, 1'b0);
      add_word(2, 1'b1);
      add_word(10, 1'b0);
      add_word(20, 1'b0);
      add_word(30, 1'b0);
      add_word(40, 1'b0);
      finish_phase();

      // window grows inside the open series
      set_length(9'd5);
      add_word(50, 1'b0);
      add_word(60, 1'b1);
      finish_phase();

      // oversized length clips to the full store
      set_length(9'd511);
      add_series(20, 1'b1);
      add_series(260, 1'b1);
      finish_phase();

      // full store, left open, then the window shrinks mid-series
      set_length(9'd256);
      add_series(257, 1'b0);
      finish_phase();
      set_length(9'd7);
      add_series(4, 1'b1);
      finish_phase();

      // random phases: mostly complete series, some short, single and open runs
      for (int p = 0; p < 7; p++) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         no_gaps = (p == 4);
         set_length(len[LEN_REG_WIDTH-1:0]);
         added = 0;
         while (added < 100) begin
            r = $urandom_range(99);
            if (r < 75) begin
               n = $urandom_range(len, 3 * len + 4);
               add_series(n, 1'b1);
            end else if (r < 85) begin
               n = $urandom_range(1, len);
               add_series(n, 1'b1);
            end else if (r < 95) begin
               n = 1;
               add_series(n, 1'b1);
            end else begin
               n = $urandom_range(1, len);
               add_series(n, 1'b0);
            end
            added = added + n;
         end
         finish_phase();
      end
      no_gaps = 1'b0;

      if (mismatch_count == 0 && stats_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(40_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/swmmm_pkg.sv
rtl/swmmm_store.sv
rtl/swmmm_div.sv
rtl/sliding_window_max_min_mean.sv
dv/tb.sv
